FILE: hw/rtl/pida_pkg.sv
// Package for the positional insert/delete array.
// Holds field widths, operation and status codes, and the shared types.
// No dependencies.
package pida_pkg;

    localparam int FUNC_W       = 2;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;
    localparam int DEF_CAPACITY = 64;

    // Operation codes carried on s_tuser.
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Broadcast command to every cell of the row.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_cmd_t;

    // Source of the read_value field of a pending result.
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_ONES,
        RD_CELL
    } rd_sel_t;

endpackage

FILE: hw/rtl/pida_cell.sv
// One storage cell of the list row: holds a single entry.
// Depends on pida_pkg; takes data from its left or right neighbor on a shift.
module pida_cell
    import pida_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
) (
    input  logic                    aclk,
    input  cell_cmd_t               cmd,
    input  logic [CMP_W-1:0]        pos_ins,
    input  logic [CMP_W-1:0]        pos,
    input  logic [CMP_W-1:0]        count,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    output logic signed [VAL_W-1:0] data_out,
    output logic signed [VAL_W-1:0] read_out
);

    localparam logic [CMP_W-1:0] IDX    = CMP_W'(INDEX);
    localparam logic [CMP_W:0]   IDX_P1 = (CMP_W + 1)'(INDEX + 1);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.do_insert) begin
            if (IDX == pos_ins) begin
                data_next = value;
            end else if ((IDX > pos_ins) && (IDX <= count)) begin
                data_next = left_data;
            end
        end else if (cmd.do_remove) begin
            // Entries from the removed slot up to the old tail move down one.
            if ((IDX >= pos) && (IDX_P1 < {1'b0, count})) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign read_out = (IDX == pos) ? data_reg : '0;

endmodule

FILE: hw/rtl/positional_insert_delete_array_top.sv
// Top level of the positional insert/delete array: a row of pida_cell entries,
// a two-level OR reduction for reads, and pending and output result registers. Depends on pida_pkg.
//
//  Channel | Dir | Ports                        | Payload
//  --------+-----+------------------------------+-------------------------------
//  input   | in  | s_tvalid s_tready s_tdata    | tuser: func; tdata: position,
//          |     | s_tuser                      |   value
//  result  | out | m_tvalid m_tready m_tdata    | tdata: read_value, status, count
//
// When an item is taken, every cell shifts or loads at once, and group OR
// registers capture the addressed entry. Its result is held in the pending
// register and moves to the output register once the output is free; a new
// item is taken every cycle while m_tready stays high.
// aresetn (synchronous) empties the list; entry contents are not cleared.
// A stalled output holds the pending result and stops new items after one.
module positional_insert_delete_array_top
    import pida_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int S_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8,
    parameter int M_DATA_W = ((VAL_W + STAT_W + CNT_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // position, value
    input  logic [FUNC_W-1:0]   s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // read_value, status, count
);

    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP    = 8;
    localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [FUNC_W-1:0]       in_func;
    logic [POS_W-1:0]        in_pos;
    logic signed [VAL_W-1:0] in_value;

    assign in_func  = s_tuser;
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+VAL_W-1:POS_W];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic              pend_valid_reg;
    rd_sel_t           pend_sel_reg;
    logic [STAT_W-1:0] pend_status_reg;
    logic [CNT_W-1:0]  pend_count_reg;

    rd_sel_t           pend_sel_next;
    logic [STAT_W-1:0] pend_status_next;

    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic [STAT_W-1:0]       m_status_reg;
    logic [CNT_W-1:0]        m_count_reg;

    logic out_free;
    logic s_fire;
    logic pend_move;

    assign out_free  = !m_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    assign s_tready  = !pend_valid_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;

    // Command decode
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pos_ins;
    logic             pos_in_range;
    logic             list_full;
    cell_cmd_t        cmd;

    assign pos_c        = CMP_W'(in_pos);
    assign cnt_c        = CMP_W'(count_reg);
    assign pos_ins      = (pos_c > cnt_c) ? cnt_c : pos_c;
    assign pos_in_range = pos_c < cnt_c;
    assign list_full    = count_reg >= CAP_CNT;

    always_comb begin
        cmd.do_insert    = 1'b0;
        cmd.do_remove    = 1'b0;
        count_next       = count_reg;
        pend_sel_next    = RD_ZERO;
        pend_status_next = ST_DONE;
        case (in_func)
            FN_INSERT: begin
                if (list_full) begin
                    pend_status_next = ST_FULL;
                end else begin
                    cmd.do_insert = s_fire;
                    count_next    = count_reg + 1'b1;
                end
            end
            FN_REMOVE: begin
                if (!pos_in_range) begin
                    pend_status_next = ST_RANGE;
                end else begin
                    cmd.do_remove = s_fire;
                    count_next    = count_reg - 1'b1;
                end
            end
            FN_READ: begin
                if (!pos_in_range) begin
                    pend_sel_next    = RD_ONES;
                    pend_status_next = ST_RANGE;
                end else begin
                    pend_sel_next = RD_CELL;
                end
            end
            default: begin
                pend_status_next = ST_RANGE;
            end
        endcase
    end

    // Row of cells
    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic signed [VAL_W-1:0] cell_rd   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_d;
        logic signed [VAL_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pida_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .pos_ins    (pos_ins),
            .pos        (pos_c),
            .count      (cnt_c),
            .value      (in_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[i]),
            .read_out   (cell_rd[i])
        );
    end

    // Read path: only the addressed cell drives nonzero, so an OR per group,
    // registered, then an OR over the groups selects it.
    logic signed [VAL_W-1:0] grp_or   [NGRP];
    logic signed [VAL_W-1:0] grp_reg  [NGRP];
    logic signed [VAL_W-1:0] read_sum;

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            grp_or[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < CAPACITY) begin
                    grp_or[g] = grp_or[g] | cell_rd[g*GRP+k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (s_fire) begin
                grp_reg[g] <= grp_or[g];
            end
        end
    end

    always_comb begin
        read_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            read_sum = read_sum | grp_reg[g];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            if (s_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_move) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pend_sel_reg    <= pend_sel_next;
            pend_status_reg <= pend_status_next;
            pend_count_reg  <= count_next;
        end
        if (pend_move) begin
            case (pend_sel_reg)
                RD_ONES: m_value_reg <= '1;
                RD_CELL: m_value_reg <= read_sum;
                default: m_value_reg <= '0;
            endcase
            m_status_reg <= pend_status_reg;
            m_count_reg  <= pend_count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_count_reg, m_status_reg, m_value_reg});

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (in_func == FN_INSERT) && !list_full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list by one");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (in_func == FN_REMOVE) && pos_in_range
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the list by one");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_FULL) |-> m_count_reg == CAP_CNT)
        else $error("full status reported on a list that is not full");

    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && (pend_sel_reg == RD_CELL) |-> pend_count_reg != '0)
        else $error("entry read from an empty list");

endmodule
